FILE: rtl/core/grlq_pkg.sv
`default_nettype none

package grlq_pkg;

    localparam int MAX_LEVELS = 12;
    localparam int DIM_BITS   = 11;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int NLEV_W     = $clog2(MAX_LEVELS + 1);

    localparam int COORD_W  = 32;
    localparam int Q_W      = COORD_W + 1;
    localparam int BND_W    = COORD_W + 2;
    localparam int EXT_W    = 31;
    localparam int CNT_W    = 32;
    localparam int DIFF_W   = Q_W;
    localparam int NUM_W    = DIFF_W + DIM_BITS;
    localparam int VIS2_W   = 2 * DIM_BITS;
    localparam int VIS_W    = 3 * DIM_BITS;
    localparam int S_W      = CNT_W + 1;
    localparam int D_W      = CNT_W;
    localparam int P_W      = VIS_W + S_W;
    localparam int MUL_B_W  = S_W;
    localparam int PROD_W   = P_W + MUL_B_W;
    localparam int OUT_W    = 31;
    localparam int ADDR_W   = 5;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_BOX    = 2'd1;
    localparam logic [1:0] CMD_RADIUS = 2'd2;

    localparam logic [2:0] REG_MIN_X  = 3'd0;
    localparam logic [2:0] REG_MIN_Y  = 3'd1;
    localparam logic [2:0] REG_MIN_Z  = 3'd2;
    localparam logic [2:0] REG_EXT_X  = 3'd3;
    localparam logic [2:0] REG_EXT_Y  = 3'd4;
    localparam logic [2:0] REG_EXT_Z  = 3'd5;
    localparam logic [2:0] REG_POINTS = 3'd6;
    localparam logic [2:0] REG_LEVELS = 3'd7;

    localparam logic [1:0] MUL_SEL_P = 2'd0;
    localparam logic [1:0] MUL_SEL_L = 2'd1;
    localparam logic [1:0] MUL_SEL_R = 2'd2;

    typedef struct packed {
        logic             in_load;
        logic             setup;
        logic             num_load;
        logic             div_start;
        logic             cell_cap;
        logic             vis1;
        logic             vis2;
        logic             mul_start;
        logic [1:0]       mul_sel;
        logic             cap_p;
        logic             cap_l;
        logic             take;
        logic             out_load;
        logic [LVL_W-1:0] lvl;
        logic [1:0]       axis;
        logic             hi_end;
    } grlq_cmd_t;

    typedef struct packed {
        logic              in_query;
        logic              miss;
        logic              trivial;
        logic              div_busy;
        logic              div_done;
        logic              mul_busy;
        logic              mul_done;
        logic              less;
        logic [NLEV_W-1:0] nlev;
    } grlq_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/grlq_div.sv
`default_nettype none

module grlq_div
    import grlq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    input  wire logic [EXT_W-1:0] den,
    output logic                  busy,
    output logic                  done,
    output logic      [NUM_W-1:0] quo
);

    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]     num_reg;
    logic [EXT_W-1:0]     rem_reg;
    logic [EXT_W-1:0]     den_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [EXT_W:0]       trial;
    logic [EXT_W:0]       trial_sub;
    logic                 ge;

    // Restoring division, one quotient bit per cycle shifted into num_reg.
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_W-1]};
        ge        = trial >= {1'b0, den_reg};
        trial_sub = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? trial_sub[EXT_W-1:0] : trial[EXT_W-1:0];
            num_reg <= {num_reg[NUM_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = num_reg;

endmodule

`default_nettype wire

FILE: rtl/core/grlq_mul.sv
`default_nettype none

module grlq_mul
    import grlq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [P_W-1:0]     a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    busy,
    output logic                    done,
    output logic      [PROD_W-1:0]  prod
);

    localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

    logic [PROD_W-1:0]    a_reg;
    logic [MUL_B_W-1:0]   b_reg;
    logic [PROD_W-1:0]    acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= MUL_CNT_W'(MUL_B_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - MUL_CNT_W'(1);
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Shift-add: one multiplier bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= PROD_W'(a);
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[PROD_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_B_W-1:1]};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

FILE: rtl/core/grlq_datapath.sv
`default_nettype none

module grlq_datapath
    import grlq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire grlq_cmd_t           cmd,
    output grlq_stat_t               st,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    input  wire logic [1:0]          command,
    input  wire logic [3:0]          level_index,
    input  wire logic [10:0]         dim_x,
    input  wire logic [10:0]         dim_y,
    input  wire logic [10:0]         dim_z,
    input  wire logic [31:0]         cell_total,
    input  wire logic signed [31:0]  lo_x,
    input  wire logic signed [31:0]  lo_y,
    input  wire logic signed [31:0]  lo_z,
    input  wire logic signed [31:0]  hi_x,
    input  wire logic signed [31:0]  hi_y,
    input  wire logic signed [31:0]  hi_z,
    output logic      [3:0]          chosen_level,
    output logic      [OUT_W-1:0]    covered_cells
);

    logic signed [COORD_W-1:0] min_reg [3];
    logic        [EXT_W-1:0]   ext_reg [3];
    logic        [CNT_W-1:0]   points_reg;
    logic        [3:0]         levels_reg;

    logic [DIM_BITS-1:0] dims_reg  [MAX_LEVELS][3];
    logic [CNT_W-1:0]    cells_reg [MAX_LEVELS];

    logic signed [Q_W-1:0] qmin_reg [3];
    logic signed [Q_W-1:0] qmax_reg [3];
    logic signed [Q_W-1:0] qmin_next [3];
    logic signed [Q_W-1:0] qmax_next [3];
    logic                  miss_reg;
    logic                  miss_next;

    logic [NUM_W-1:0]    num_reg;
    logic [NUM_W-1:0]    num_next;
    logic                trivial_reg;
    logic                trivial_next;
    logic [DIM_BITS-1:0] lim_reg;
    logic [DIM_BITS-1:0] cell_next;
    logic [DIM_BITS-1:0] c0_reg;
    logic [DIM_BITS-1:0] span_reg [3];
    logic [VIS2_W-1:0]   vis_a_reg;
    logic [VIS_W-1:0]    vis_reg;

    logic [P_W-1:0]      p_reg;
    logic [PROD_W-1:0]   l_reg;
    logic [LVL_W-1:0]    best_lvl_reg;
    logic [VIS_W-1:0]    best_v_reg;
    logic [D_W-1:0]      best_d_reg;
    logic [P_W-1:0]      p_best_reg;

    logic [S_W-1:0]      s_cur;
    logic [D_W-1:0]      d_cur;
    logic [DIM_BITS-1:0] dim_sel;
    logic [NLEV_W-1:0]   nlev;

    logic                div_busy;
    logic                div_done;
    logic [NUM_W-1:0]    quo;
    logic [P_W-1:0]      mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic                mul_busy;
    logic                mul_done;
    logic [PROD_W-1:0]   prod;

    logic                cfg_write;
    logic                load_ok;

    assign cfg_write = psel && penable && pwrite;
    assign load_ok   = cmd.in_load && (command == CMD_LOAD)
                       && ({1'b0, level_index} < 5'(MAX_LEVELS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a] <= '0;
                ext_reg[a] <= '0;
            end
            points_reg <= '0;
            levels_reg <= 4'd2;
        end
        else if (cfg_write)
        begin
            case (paddr[4:2])
                REG_MIN_X:  min_reg[0] <= pwdata;
                REG_MIN_Y:  min_reg[1] <= pwdata;
                REG_MIN_Z:  min_reg[2] <= pwdata;
                REG_EXT_X:  ext_reg[0] <= pwdata[EXT_W-1:0];
                REG_EXT_Y:  ext_reg[1] <= pwdata[EXT_W-1:0];
                REG_EXT_Z:  ext_reg[2] <= pwdata[EXT_W-1:0];
                REG_POINTS: points_reg <= pwdata;
                REG_LEVELS: levels_reg <= pwdata[3:0];
                default:    levels_reg <= levels_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_MIN_X:  prdata = min_reg[0];
            REG_MIN_Y:  prdata = min_reg[1];
            REG_MIN_Z:  prdata = min_reg[2];
            REG_EXT_X:  prdata = {1'b0, ext_reg[0]};
            REG_EXT_Y:  prdata = {1'b0, ext_reg[1]};
            REG_EXT_Z:  prdata = {1'b0, ext_reg[2]};
            REG_POINTS: prdata = points_reg;
            REG_LEVELS: prdata = {28'd0, levels_reg};
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                dims_reg[l][0] <= '0;
                dims_reg[l][1] <= '0;
                dims_reg[l][2] <= '0;
                cells_reg[l]   <= '0;
            end
        end
        else if (load_ok)
        begin
            dims_reg[level_index[LVL_W-1:0]][0] <= dim_x[DIM_BITS-1:0];
            dims_reg[level_index[LVL_W-1:0]][1] <= dim_y[DIM_BITS-1:0];
            dims_reg[level_index[LVL_W-1:0]][2] <= dim_z[DIM_BITS-1:0];
            cells_reg[level_index[LVL_W-1:0]]   <= cell_total;
        end
    end

    // Query box; a radius query spans center-radius to center+radius.
    always_comb
    begin
        logic signed [Q_W-1:0] rad;
        logic signed [Q_W-1:0] ctr [3];
        rad    = Q_W'(hi_x);
        ctr[0] = Q_W'(lo_x);
        ctr[1] = Q_W'(lo_y);
        ctr[2] = Q_W'(lo_z);
        if (command == CMD_RADIUS)
        begin
            for (int a = 0; a < 3; a++)
            begin
                qmin_next[a] = ctr[a] - rad;
                qmax_next[a] = ctr[a] + rad;
            end
        end
        else
        begin
            for (int a = 0; a < 3; a++)
            begin
                qmin_next[a] = ctr[a];
            end
            qmax_next[0] = Q_W'(hi_x);
            qmax_next[1] = Q_W'(hi_y);
            qmax_next[2] = Q_W'(hi_z);
        end
    end

    always_comb
    begin
        logic signed [BND_W-1:0] lo;
        logic signed [BND_W-1:0] hi;
        logic signed [BND_W-1:0] mn;
        logic signed [BND_W-1:0] bmax;
        miss_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            lo   = BND_W'(qmin_reg[a]);
            hi   = BND_W'(qmax_reg[a]);
            mn   = BND_W'(min_reg[a]);
            bmax = mn + $signed({3'b000, ext_reg[a]});
            if (lo > hi || hi < mn || lo > bmax)
            begin
                miss_next = 1'b1;
            end
        end
    end

    assign dim_sel = dims_reg[cmd.lvl][cmd.axis];

    // Scaled offset of one box corner; a negative offset lands in cell 0.
    always_comb
    begin
        logic signed [Q_W-1:0]   v;
        logic signed [BND_W-1:0] diff;
        v            = cmd.hi_end ? qmax_reg[cmd.axis] : qmin_reg[cmd.axis];
        diff         = BND_W'(v) - BND_W'(min_reg[cmd.axis]);
        num_next     = NUM_W'(diff[DIFF_W-1:0]) * NUM_W'(dim_sel);
        trivial_next = (dim_sel <= DIM_BITS'(1)) || (ext_reg[cmd.axis] == '0)
                       || diff[BND_W-1];
    end

    always_comb
    begin
        if (trivial_reg)
        begin
            cell_next = '0;
        end
        else if (quo > NUM_W'(lim_reg))
        begin
            cell_next = lim_reg;
        end
        else
        begin
            cell_next = quo[DIM_BITS-1:0];
        end
    end

    always_comb
    begin
        logic [CNT_W-1:0] c;
        c = cells_reg[cmd.lvl];
        if (c != '0)
        begin
            s_cur = S_W'(c) + S_W'(points_reg);
            d_cur = c;
        end
        else
        begin
            s_cur = S_W'(points_reg) + S_W'(1);
            d_cur = D_W'(1);
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_SEL_P:
            begin
                mul_a = P_W'(vis_reg);
                mul_b = s_cur;
            end
            MUL_SEL_L:
            begin
                mul_a = p_reg;
                mul_b = MUL_B_W'(best_d_reg);
            end
            MUL_SEL_R:
            begin
                mul_a = p_best_reg;
                mul_b = MUL_B_W'(d_cur);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_reg     <= 1'b0;
            trivial_reg  <= 1'b0;
            best_lvl_reg <= '0;
        end
        else
        begin
            if (cmd.setup)
            begin
                miss_reg     <= miss_next;
                best_lvl_reg <= '0;
            end
            else if (cmd.take)
            begin
                best_lvl_reg <= cmd.lvl;
            end
            if (cmd.num_load)
            begin
                trivial_reg <= trivial_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            for (int a = 0; a < 3; a++)
            begin
                qmin_reg[a] <= qmin_next[a];
                qmax_reg[a] <= qmax_next[a];
            end
        end
        if (cmd.num_load)
        begin
            num_reg <= num_next;
            lim_reg <= dim_sel - DIM_BITS'(1);
        end
        if (cmd.cell_cap)
        begin
            if (!cmd.hi_end)
            begin
                c0_reg <= cell_next;
            end
            else
            begin
                span_reg[cmd.axis] <= cell_next - c0_reg + DIM_BITS'(1);
            end
        end
        if (cmd.vis1)
        begin
            vis_a_reg <= VIS2_W'(span_reg[0]) * VIS2_W'(span_reg[1]);
        end
        if (cmd.vis2)
        begin
            vis_reg <= VIS_W'(vis_a_reg) * VIS_W'(span_reg[2]);
        end
        if (cmd.cap_p)
        begin
            p_reg <= prod[P_W-1:0];
        end
        if (cmd.cap_l)
        begin
            l_reg <= prod;
        end
        if (cmd.setup)
        begin
            best_v_reg <= '0;
        end
        else if (cmd.take)
        begin
            best_v_reg <= vis_reg;
            best_d_reg <= d_cur;
            p_best_reg <= p_reg;
        end
        if (cmd.out_load)
        begin
            chosen_level  <= 4'(best_lvl_reg);
            covered_cells <= (best_v_reg > VIS_W'({OUT_W{1'b1}}))
                             ? {OUT_W{1'b1}} : OUT_W'(best_v_reg);
        end
    end

    grlq_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_reg),
        .den   (ext_reg[cmd.axis]),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (quo)
    );

    grlq_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .done  (mul_done),
        .prod  (prod)
    );

    always_comb
    begin
        if (levels_reg < 4'd2)
        begin
            nlev = NLEV_W'(2);
        end
        else if ({1'b0, levels_reg} > 5'(MAX_LEVELS))
        begin
            nlev = NLEV_W'(MAX_LEVELS);
        end
        else
        begin
            nlev = NLEV_W'(levels_reg);
        end
    end

    always_comb
    begin
        st.in_query = (command == CMD_BOX) || (command == CMD_RADIUS);
        st.miss     = miss_reg;
        st.trivial  = trivial_reg;
        st.div_busy = div_busy;
        st.div_done = div_done;
        st.mul_busy = mul_busy;
        st.mul_done = mul_done;
        st.less     = l_reg < prod;
        st.nlev     = nlev;
    end

endmodule

`default_nettype wire

FILE: rtl/core/grlq_ctrl.sv
`default_nettype none

module grlq_ctrl
    import grlq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire grlq_stat_t st,
    output grlq_cmd_t       cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_BRANCH,
        S_AXIS,
        S_DIVGO,
        S_DIVW,
        S_CAPT,
        S_VIS1,
        S_VIS2,
        S_PGO,
        S_PW,
        S_TAKE,
        S_LGO,
        S_LW,
        S_RGO,
        S_RW,
        S_NEXT,
        S_DONE
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [LVL_W-1:0] lvl_reg;
    logic [1:0]       axis_reg;
    logic             hi_reg;
    logic             out_valid_reg;
    logic             out_free;
    logic             last_lvl;

    assign out_free = !out_valid_reg || out_ready;
    assign last_lvl = (NLEV_W'(lvl_reg) + NLEV_W'(1)) >= st.nlev;

    always_comb
    begin
        cmd         = '0;
        cmd.lvl     = lvl_reg;
        cmd.axis    = axis_reg;
        cmd.hi_end  = hi_reg;
        in_ready    = 1'b0;
        state_next  = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
                if (in_valid && st.in_query)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.setup  = 1'b1;
                state_next = S_BRANCH;
            end
            S_BRANCH:
            begin
                // A box that misses the bounds costs nothing on any level.
                state_next = st.miss ? S_DONE : S_AXIS;
            end
            S_AXIS:
            begin
                cmd.num_load = 1'b1;
                state_next   = S_DIVGO;
            end
            S_DIVGO:
            begin
                if (st.trivial)
                begin
                    state_next = S_CAPT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIVW;
                end
            end
            S_DIVW:
            begin
                if (st.div_done)
                begin
                    state_next = S_CAPT;
                end
            end
            S_CAPT:
            begin
                cmd.cell_cap = 1'b1;
                if (!hi_reg || axis_reg != 2'd2)
                begin
                    state_next = S_AXIS;
                end
                else
                begin
                    state_next = S_VIS1;
                end
            end
            S_VIS1:
            begin
                cmd.vis1   = 1'b1;
                state_next = S_VIS2;
            end
            S_VIS2:
            begin
                cmd.vis2   = 1'b1;
                state_next = S_PGO;
            end
            S_PGO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_P;
                state_next    = S_PW;
            end
            S_PW:
            begin
                if (st.mul_done)
                begin
                    cmd.cap_p  = 1'b1;
                    state_next = (lvl_reg == '0) ? S_TAKE : S_LGO;
                end
            end
            S_TAKE:
            begin
                cmd.take   = 1'b1;
                state_next = S_NEXT;
            end
            S_LGO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_L;
                state_next    = S_LW;
            end
            S_LW:
            begin
                if (st.mul_done)
                begin
                    cmd.cap_l  = 1'b1;
                    state_next = S_RGO;
                end
            end
            S_RGO:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel   = MUL_SEL_R;
                state_next    = S_RW;
            end
            S_RW:
            begin
                if (st.mul_done)
                begin
                    cmd.take   = st.less;
                    state_next = S_NEXT;
                end
            end
            S_NEXT:
            begin
                state_next = last_lvl ? S_DONE : S_AXIS;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            axis_reg      <= '0;
            hi_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                S_CHECK:
                begin
                    lvl_reg  <= '0;
                    axis_reg <= '0;
                    hi_reg   <= 1'b0;
                end
                S_CAPT:
                begin
                    hi_reg <= !hi_reg;
                    if (hi_reg)
                    begin
                        axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
                    end
                end
                S_NEXT:
                begin
                    if (!last_lvl)
                    begin
                        lvl_reg <= lvl_reg + LVL_W'(1);
                    end
                end
                default:
                begin
                    lvl_reg <= lvl_reg;
                end
            endcase
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !st.div_busy)
        else $error("divider started while busy");

    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !st.mul_busy)
        else $error("multiplier started while busy");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before it was taken");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AXIS) |-> (NLEV_W'(lvl_reg) < st.nlev))
        else $error("level counter beyond level count");

endmodule

`default_nettype wire

FILE: rtl/core/grid_level_query_router_core.sv
`default_nettype none

// Grid level query router. A load item (command 0) writes one level entry,
// if its level index is below twelve, and gives no result. A box or radius
// query gives one result: the level with the lowest estimated cost and the
// cells covered there. A query that misses the scene bounds skips the level
// loop. Otherwise each considered level runs the six corner cell divisions
// on the shared bit-serial divider (skipped for an axis with one cell or zero
// extent, or a corner below the scene minimum), plus the shared shift-add
// multiplier once on the first level and three times on each later level for
// the exact cost compare. Only one item is worked on at a time; a finished
// result waits in the output register while the next item is accepted.
module grid_level_query_router_core
    import grlq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ADDR_W-1:0]   paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [1:0]          command,
    input  wire logic [3:0]          level_index,
    input  wire logic [10:0]         dim_x,
    input  wire logic [10:0]         dim_y,
    input  wire logic [10:0]         dim_z,
    input  wire logic [31:0]         cell_total,
    input  wire logic signed [31:0]  lo_x,
    input  wire logic signed [31:0]  lo_y,
    input  wire logic signed [31:0]  lo_z,
    input  wire logic signed [31:0]  hi_x,
    input  wire logic signed [31:0]  hi_y,
    input  wire logic signed [31:0]  hi_z,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [3:0]          chosen_level,
    output logic      [OUT_W-1:0]    covered_cells
);

    grlq_cmd_t  cmd;
    grlq_stat_t st;

    assign pready = 1'b1;

    grlq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    grlq_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .st            (st),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .command       (command),
        .level_index   (level_index),
        .dim_x         (dim_x),
        .dim_y         (dim_y),
        .dim_z         (dim_z),
        .cell_total    (cell_total),
        .lo_x          (lo_x),
        .lo_y          (lo_y),
        .lo_z          (lo_z),
        .hi_x          (hi_x),
        .hi_y          (hi_y),
        .hi_z          (hi_z),
        .chosen_level  (chosen_level),
        .covered_cells (covered_cells)
    );

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`default_nettype none

module tb_top
    import grlq_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        logic [1:0]         command;
        logic [3:0]         level_index;
        logic [10:0]        dim_x, dim_y, dim_z;
        logic [31:0]        cell_total;
        logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    } query_item_t;

    typedef struct {
        logic [3:0]       level;
        logic [OUT_W-1:0] cells;
    } route_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0, in_ready;
    logic [1:0] command = CMD_LOAD;
    logic [3:0] level_index = '0;
    logic [10:0] dim_x = '0, dim_y = '0, dim_z = '0;
    logic [31:0] cell_total = '0;
    logic signed [31:0] lo_x = '0, lo_y = '0, lo_z = '0, hi_x = '0, hi_y = '0, hi_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [3:0] chosen_level;
    logic [OUT_W-1:0] covered_cells;

    always #4 clk = ~clk;

    grid_level_query_router_core dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .level_index(level_index),
        .dim_x(dim_x), .dim_y(dim_y), .dim_z(dim_z), .cell_total(cell_total),
        .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .chosen_level(chosen_level), .covered_cells(covered_cells)
    );

    // Shadow copy of the level table and registers.
    logic [10:0] tbl_dim [MAX_LEVELS][3];
    logic [31:0] tbl_cells [MAX_LEVELS];
    longint      scene_min [3];
    longint      scene_ext [3];
    logic [31:0] scene_points;
    logic [3:0]  scene_levels;

    route_t pending_routes [$];
    int mismatches = 0;
    int loads_sent = 0, queries_sent = 0, routes_seen = 0, saturated_seen = 0;
    int burst_left = 0, gap_len = 0, gap_max = 4;
    int hold_off = 0, stall_pct = 0;

    function automatic longint cell_index(longint v, longint mn, longint ext, int dim);
        longint num, q;
        if (dim <= 1 || ext <= 0)
            return 0;
        num = (v - mn) * longint'(dim);
        q = num / ext;
        if ((num % ext) != 0 && num < 0)
            q--;
        if (q < 0)
            q = 0;
        if (q > longint'(dim) - 1)
            q = longint'(dim) - 1;
        return q;
    endfunction

    function automatic longint unsigned cells_covered(longint qmin[3], longint qmax[3], int lvl);
        longint unsigned total = 1;
        longint c0, c1;
        for (int a = 0; a < 3; a++)
        begin
            if (qmin[a] > qmax[a])
                return 0;
            if (qmax[a] < scene_min[a] || qmin[a] > scene_min[a] + scene_ext[a])
                return 0;
        end
        for (int a = 0; a < 3; a++)
        begin
            c0 = cell_index(qmin[a], scene_min[a], scene_ext[a], int'(tbl_dim[lvl][a]));
            c1 = cell_index(qmax[a], scene_min[a], scene_ext[a], int'(tbl_dim[lvl][a]));
            total *= longint'(c1 - c0 + 1);
        end
        return total;
    endfunction

    // Exact a/b < c/d style compare of the two level costs.
    function automatic bit cheaper(longint unsigned va, longint unsigned sa, longint unsigned da,
                                   longint unsigned vb, longint unsigned sb, longint unsigned db);
        logic [127:0] lhs, rhs;
        lhs = 128'(va);
        lhs = lhs * sa * db;
        rhs = 128'(vb);
        rhs = rhs * sb * da;
        return lhs < rhs;
    endfunction

    function automatic void route_query(query_item_t it);
        longint qmin[3], qmax[3], rad;
        longint unsigned vis, s, d, bv, bs, bd;
        int nlev, best;
        route_t r;
        if (it.command == CMD_RADIUS)
        begin
            rad = longint'(it.hi_x);
            qmin[0] = longint'(it.lo_x) - rad; qmax[0] = longint'(it.lo_x) + rad;
            qmin[1] = longint'(it.lo_y) - rad; qmax[1] = longint'(it.lo_y) + rad;
            qmin[2] = longint'(it.lo_z) - rad; qmax[2] = longint'(it.lo_z) + rad;
        end
        else
        begin
            qmin[0] = longint'(it.lo_x); qmin[1] = longint'(it.lo_y);
            qmin[2] = longint'(it.lo_z);
            qmax[0] = longint'(it.hi_x); qmax[1] = longint'(it.hi_y);
            qmax[2] = longint'(it.hi_z);
        end
        nlev = int'(scene_levels);
        if (nlev < 2)
            nlev = 2;
        if (nlev > MAX_LEVELS)
            nlev = MAX_LEVELS;
        best = 0; bv = 0; bs = 0; bd = 1;
        for (int i = 0; i < nlev; i++)
        begin
            vis = cells_covered(qmin, qmax, i);
            if (tbl_cells[i] != 0)
            begin
                s = longint'(tbl_cells[i]) + longint'(scene_points);
                d = 64'(tbl_cells[i]);
            end
            else
            begin
                s = longint'(scene_points) + 1;
                d = 1;
            end
            if (i == 0 || cheaper(vis, s, d, bv, bs, bd))
            begin
                best = i; bv = vis; bs = s; bd = d;
            end
        end
        r.level = 4'(best);
        r.cells = (bv > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : bv[30:0];
        pending_routes = {pending_routes, r};
    endfunction

    function automatic void apply_item(query_item_t it);
        if (it.command == CMD_LOAD)
        begin
            loads_sent++;
            if (it.level_index < MAX_LEVELS)
            begin
                tbl_dim[it.level_index][0] = it.dim_x;
                tbl_dim[it.level_index][1] = it.dim_y;
                tbl_dim[it.level_index][2] = it.dim_z;
                tbl_cells[it.level_index] = it.cell_total;
            end
        end
        else if (it.command != CMD_NONE)
        begin
            queries_sent++;
            route_query(it);
        end
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MIN_X: scene_min[0] = longint'(signed'(val));
            REG_MIN_Y: scene_min[1] = longint'(signed'(val));
            REG_MIN_Z: scene_min[2] = longint'(signed'(val));
            REG_EXT_X: scene_ext[0] = longint'(val[30:0]);
            REG_EXT_Y: scene_ext[1] = longint'(val[30:0]);
            REG_EXT_Z: scene_ext[2] = longint'(val[30:0]);
            REG_POINTS: scene_points = val;
            REG_LEVELS: scene_levels = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_scene(input logic [31:0] mn, input logic [31:0] ext,
                             input logic [31:0] pts, input logic [3:0] nlev);
        reg_write(REG_MIN_X, mn);
        reg_write(REG_MIN_Y, mn + 32'h0001_0000);
        reg_write(REG_MIN_Z, mn - 32'h0003_0000);
        reg_write(REG_EXT_X, ext);
        reg_write(REG_EXT_Y, ext);
        reg_write(REG_EXT_Z, {1'b0, ext[30:0]} >> 1);
        reg_write(REG_POINTS, pts);
        reg_write(REG_LEVELS, {28'd0, nlev});
    endtask

    task automatic send_item(input query_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap_len = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        end
        burst_left--;
        @(negedge clk);
        if (gap_len > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len) @(negedge clk);
            gap_len = 0;
        end
        command <= it.command; level_index <= it.level_index;
        dim_x <= it.dim_x; dim_y <= it.dim_y; dim_z <= it.dim_z;
        cell_total <= it.cell_total;
        lo_x <= it.lo_x; lo_y <= it.lo_y; lo_z <= it.lo_z;
        hi_x <= it.hi_x; hi_y <= it.hi_y; hi_z <= it.hi_z;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        apply_item(it);
    endtask

    // Drop valid and let every outstanding result come back before a register write.
    task automatic drain;
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending_routes.size() == 0);
        repeat (20) @(posedge clk);
    endtask

    function automatic query_item_t load_item(int idx, int dx, int dy, int dz, logic [31:0] ct);
        query_item_t it = '{default: '0};
        it.command = CMD_LOAD;
        it.level_index = 4'(idx); it.dim_x = 11'(dx); it.dim_y = 11'(dy); it.dim_z = 11'(dz);
        it.cell_total = ct;
        return it;
    endfunction

    function automatic query_item_t box_item(logic [1:0] cmd, logic [31:0] lx, logic [31:0] ly,
                                             logic [31:0] lz, logic [31:0] hx, logic [31:0] hy,
                                             logic [31:0] hz);
        query_item_t it = '{default: '0};
        it.command = cmd;
        it.lo_x = lx; it.lo_y = ly; it.lo_z = lz;
        it.hi_x = hx; it.hi_y = hy; it.hi_z = hz;
        it.level_index = 4'($urandom); it.cell_total = $urandom;
        it.dim_x = 11'($urandom); it.dim_y = 11'($urandom); it.dim_z = 11'($urandom);
        return it;
    endfunction

    // Mostly inside the scene, sometimes anywhere.
    function automatic logic [31:0] pick_coord(int a);
        longint off;
        if ($urandom_range(0, 9) < 2 || scene_ext[a] == 0)
            return $urandom;
        off = longint'($urandom) % (scene_ext[a] + 1);
        return 32'(scene_min[a] + off);
    endfunction

    function automatic query_item_t random_load;
        int dmax = ($urandom_range(0, 9) == 0) ? 2047 : 64;
        return load_item($urandom_range(0, 9) == 0 ? $urandom_range(12, 15) : $urandom_range(0, 11),
                         $urandom_range(0, dmax), $urandom_range(0, dmax),
                         $urandom_range(0, dmax),
                         $urandom_range(0, 3) == 0 ? 32'd0 : $urandom);
    endfunction

    function automatic query_item_t random_query;
        logic [31:0] a0, a1, b0, b1, c0, c1;
        int roll = $urandom_range(0, 19);
        a0 = pick_coord(0); a1 = pick_coord(0);
        b0 = pick_coord(1); b1 = pick_coord(1);
        c0 = pick_coord(2); c1 = pick_coord(2);
        if (roll == 0)
            return box_item(CMD_NONE, a0, b0, c0, a1, b1, c1);
        if (roll < 7)
            return box_item(CMD_RADIUS, a0, b0, c0, $urandom_range(0, 9) == 0 ? $urandom
                            : $urandom_range(0, 32'h0040_0000), b1, c1);
        // Ordered corners most of the time so that the cell math is exercised.
        if (roll < 17)
            return box_item(CMD_BOX, signed'(a0) < signed'(a1) ? a0 : a1,
                            signed'(b0) < signed'(b1) ? b0 : b1,
                            signed'(c0) < signed'(c1) ? c0 : c1,
                            signed'(a0) < signed'(a1) ? a1 : a0,
                            signed'(b0) < signed'(b1) ? b1 : b0,
                            signed'(c0) < signed'(c1) ? c1 : c0);
        return box_item(CMD_BOX, a0, b0, c0, a1, b1, c1);
    endfunction

    task automatic test_reset_state;
        send_item(box_item(CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(box_item(CMD_BOX, 32'h10, 0, 0, 32'h20, 0, 0));
        drain();
    endtask

    task automatic test_directed;
        set_scene(32'h0000_0000, 32'h0064_0000, 32'd1000, 4'd12);
        send_item(load_item(0, 2047, 2047, 2047, 32'hFFFF_FFFF));
        send_item(load_item(1, 0, 1, 0, 32'd0));
        send_item(load_item(2, 16, 16, 16, 32'd500));
        send_item(load_item(3, 1024, 1, 1024, 32'd1));
        send_item(load_item(11, 8, 8, 8, 32'd8));
        send_item(load_item(12, 5, 5, 5, 32'd5));
        send_item(load_item(15, 9, 9, 9, 32'd9));
        send_item(box_item(CMD_NONE, 0, 0, 0, 32'h10_0000, 32'h10_0000, 32'h10_0000));
        // Whole scene query; level 0 has a 2047-cube grid, but a cheaper level is chosen.
        send_item(box_item(CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(box_item(CMD_BOX, 32'h0020_0000, 32'h0020_0000, 32'h0010_0000,
                           32'h0030_0000, 32'h0030_0000, 32'h0020_0000));
        send_item(box_item(CMD_BOX, 32'h0030_0000, 0, 0, 32'h0020_0000, 32'h10, 32'h10));
        send_item(box_item(CMD_BOX, 32'h7000_0000, 0, 0, 32'h7FFF_FFFF, 32'h10, 32'h10));
        send_item(box_item(CMD_RADIUS, 32'h0032_0000, 32'h0032_0000, 32'h0010_0000,
                           32'h0005_0000, 0, 0));
        send_item(box_item(CMD_RADIUS, 32'h0032_0000, 32'h0032_0000, 32'h0010_0000,
                           32'hFFFF_0000, 0, 0));
        send_item(box_item(CMD_RADIUS, 32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 0));
        drain();
        // Level count below and above its range is clamped; extremes of the scene.
        set_scene(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 4'd0);
        send_item(box_item(CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        drain();
        set_scene(32'h7FFF_FFFF, 32'h0, 32'd0, 4'd15);
        send_item(box_item(CMD_BOX, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFC_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_item(box_item(CMD_RADIUS, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFC_FFFF,
                           32'h7FFF_FFFF, 0, 0));
        drain();
        set_scene(32'h8000_0000, 32'h0, 32'd1, 4'd1);
        send_item(box_item(CMD_BOX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8001_0000, 32'h8000_0000));
        drain();
    endtask

    task automatic test_random_phases;
        logic [31:0] ext;
        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: ext = $urandom_range(1, 32'h0100_0000);
                1: ext = $urandom_range(1, 64);
                default: ext = $urandom;
            endcase
            gap_max = (phase == 2) ? 0 : 5;
            set_scene($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000),
                      ext, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 2000),
                      4'($urandom_range(0, 15)));
            for (int k = 0; k < 30; k++)
                send_item(($urandom_range(0, 2) == 0) ? random_load() : random_query());
            drain();
        end
    endtask

    task automatic test_receiver_backpressure;
        gap_max = 2;
        hold_off = 3000;
        for (int k = 0; k < 12; k++)
            send_item(($urandom_range(0, 3) == 0) ? random_load() : random_query());
        drain();
        gap_max = 4;
        for (int k = 0; k < 10; k++)
            send_item(random_query());
        drain();
        for (int k = 0; k < 10; k++)
            send_item(($urandom_range(0, 1) == 0) ? random_load() : random_query());
        drain();
    endtask

    // Result side: ready pattern and compare.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off--;
            out_ready <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(20, 80);
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        route_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            routes_seen++;
            if (covered_cells == 31'h7FFF_FFFF)
                saturated_seen++;
            if (pending_routes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: level %0d cells %0d", chosen_level,
                             covered_cells);
            end
            else
            begin
                exp_r = pending_routes.pop_front();
                if (chosen_level !== exp_r.level || covered_cells !== exp_r.cells)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: level exp %0d got %0d, cells exp %0d got %0d",
                                 exp_r.level, chosen_level, exp_r.cells, covered_cells);
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            tbl_cells[i] = '0;
            for (int a = 0; a < 3; a++)
                tbl_dim[i][a] = '0;
        end
        for (int a = 0; a < 3; a++)
        begin
            scene_min[a] = 0;
            scene_ext[a] = 0;
        end
        scene_points = '0;
        scene_levels = 4'd2;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_state();
        test_directed();
        test_random_phases();
        test_receiver_backpressure();
        drain();
        repeat (100) @(posedge clk);
        $display("Ran %0d loads and %0d queries, %0d routes checked (%0d saturated covers).",
                 loads_sent, queries_sent, routes_seen, saturated_seen);
        $display("Covered scene extremes, clamped level counts, misses, radius and stalls.");
        if (mismatches == 0 && pending_routes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d results outstanding", pending_routes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
